FILE: design/qslerp_pkg.sv
// Shared types, constants and constant functions of the quaternion slerp pipeline.
package qslerp_pkg;

  localparam int FRAC_BITS_DEF    = 22;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int FIELD_W = 24;
  localparam int BEXT_W  = FIELD_W + 1;
  localparam int PROD_W  = 2 * FIELD_W;
  localparam int CW      = 40;
  localparam int DW      = 72;
  localparam int MW      = 64;
  localparam int IN_FRAC = 32;
  localparam int SQRT_N  = 32;

  localparam int THR_W  = 23;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [THR_W-1:0] THR_RESET      = 23'd4193885;
  localparam logic [CW-1:0]    CORDIC_GAIN    = 40'h00_9B74_EDA8;
  localparam logic [63:0]      QUARTER_PI_Q62 = 64'h3243_F6A8_885A_308D;

  // Register indexes on the configuration port.
  typedef enum logic [ADDR_W-3:0] {
    REG_CLOSE_THR = 1'b0
  } qs_reg_e;

  typedef struct packed {
    logic [3:0][FIELD_W-1:0] a;
    logic [3:0][BEXT_W-1:0]  b;
    logic [FIELD_W-1:0]      t;
    logic                    byp_a;
    logic                    byp_b;
    logic                    lin;
    logic [3:0][PROD_W-1:0]  p;
    logic [CW-1:0]           cosv;
    logic [31:0]             c;
    logic [63:0]             rem;
    logic [63:0]             root;
    logic [CW-1:0]           sw;
    logic [CW-1:0]           vx;
    logic [CW-1:0]           vy;
    logic [CW-1:0]           vz;
    logic [CW-1:0]           x0;
    logic [CW-1:0]           y0;
    logic [CW-1:0]           z0;
    logic [CW-1:0]           x1;
    logic [CW-1:0]           y1;
    logic [CW-1:0]           z1;
    logic [DW-1:0]           n0;
    logic [DW-1:0]           n1;
    logic [CW-1:0]           q0;
    logic [CW-1:0]           q1;
    logic                    ng0;
    logic                    ng1;
    logic                    ov0;
    logic                    ov1;
    logic [CW-1:0]           k0;
    logic [CW-1:0]           k1;
    logic [3:0][MW-1:0]      m0;
    logic [3:0][MW-1:0]      m1;
    logic [3:0][FIELD_W-1:0] res;
    logic                    ul;
  } qs_item_t;

  // Number of register stages after the input register.
  function automatic int stage_count(input int frac_bits, input int cordic_steps);
    return 13 + SQRT_N + 2 * cordic_steps + frac_bits;
  endfunction

  // atan(2^-i) in Q32, from a truncated Taylor series in Q62.
  function automatic logic [CW-1:0] atan_q32(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned k;
    acc = 64'd0;
    if (i == 0) begin
      acc = QUARTER_PI_Q62;
    end else begin
      for (k = 0; i * (2 * k + 1) <= 62; k++) begin
        term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return {{(CW-34){1'b0}}, acc[63:30]};
  endfunction

endpackage

FILE: design/qslerp_step.sv
// Datapath of one pipeline stage of the slerp unit, selected by its stage number.
module qslerp_step import qslerp_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int STAGE        = 1
) (
  input  logic [THR_W-1:0] thr_i,
  input  qs_item_t         d_i,
  output qs_item_t         q_o
);

  localparam int ST_PROD  = 1;
  localparam int ST_DOT   = 2;
  localparam int ST_ABS   = 3;
  localparam int ST_SQR   = 4;
  localparam int ST_SQRT  = 5;
  localparam int ST_VINIT = ST_SQRT + SQRT_N;
  localparam int ST_VEC   = ST_VINIT + 1;
  localparam int ST_THETA = ST_VEC + CORDIC_STEPS;
  localparam int ST_ROT   = ST_THETA + 1;
  localparam int ST_WINIT = ST_ROT + CORDIC_STEPS;
  localparam int ST_DIV   = ST_WINIT + 1;
  localparam int DIV_N    = FRAC_BITS + 3;
  localparam int ST_KFIN  = ST_DIV + DIV_N;
  localparam int ST_MUL   = ST_KFIN + 1;
  localparam int ST_SUM   = ST_MUL + 1;

  localparam int SQJ = (STAGE >= ST_SQRT && STAGE < ST_VINIT) ? STAGE - ST_SQRT : 0;
  localparam int VI  = (STAGE >= ST_VEC && STAGE < ST_THETA) ? STAGE - ST_VEC : 0;
  localparam int RI  = (STAGE >= ST_ROT && STAGE < ST_WINIT) ? STAGE - ST_ROT : 0;
  localparam int DJ  = (STAGE >= ST_DIV && STAGE < ST_KFIN) ? STAGE - ST_DIV : 0;
  localparam int POS = DIV_N - 1 - DJ;
  localparam int SH  = IN_FRAC - FRAC_BITS;
  localparam int KW  = FRAC_BITS + 4;

  localparam logic signed [CW-1:0] ANG_V = atan_q32(VI);
  localparam logic signed [CW-1:0] ANG_R = atan_q32(RI);
  localparam logic signed [CW-1:0] ONE_C = CW'(64'd1 << FRAC_BITS);
  localparam logic signed [CW-1:0] KMAX  = CW'(64'd1 << (FRAC_BITS + 2));
  localparam logic signed [FIELD_W-1:0] SAT_HI = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] SAT_LO = {1'b1, {(FIELD_W-1){1'b0}}};

  always_comb begin
    logic signed [CW-1:0]  tt, cs, xa, ya, za, xb, yb, zb, xs, ys, om, w0, mag, kk, kl;
    logic signed [49:0]    dot, dsr;
    logic signed [MW-1:0]  ma, mb, sm, sv;
    logic [63:0]           bitv, cc, pa, pb;
    logic [DW-1:0]         n, dsh;
    q_o = d_i;
    tt  = {{(CW-FIELD_W){d_i.t[FIELD_W-1]}}, d_i.t};
    if (STAGE == ST_PROD) begin
      for (int i = 0; i < 4; i++) begin
        q_o.p[i] = $signed(d_i.a[i]) * $signed(d_i.b[i][FIELD_W-1:0]);
      end
      q_o.byp_a = tt <= 0;
      q_o.byp_b = tt >= ONE_C;
    end else if (STAGE == ST_DOT) begin
      dot = '0;
      for (int i = 0; i < 4; i++) begin
        dot = dot + $signed({{2{d_i.p[i][PROD_W-1]}}, d_i.p[i]});
      end
      dsr = dot >>> FRAC_BITS;
      q_o.cosv = dsr[CW-1:0];
    end else if (STAGE == ST_ABS) begin
      cs = $signed(d_i.cosv);
      if (cs < 0) begin
        cs = -cs;
        if (!d_i.byp_a && !d_i.byp_b) begin
          for (int i = 0; i < 4; i++) begin
            q_o.b[i] = -d_i.b[i];
          end
        end
      end
      q_o.cosv = cs;
      q_o.lin  = cs > $signed({{(CW-THR_W){1'b0}}, thr_i});
      q_o.c    = (cs > ONE_C) ? ONE_C[31:0] : cs[31:0];
    end else if (STAGE == ST_SQR) begin
      cc        = d_i.c * d_i.c;
      q_o.rem   = (64'd1 << (2 * FRAC_BITS)) - cc;
      q_o.root  = '0;
    end else if (STAGE >= ST_SQRT && STAGE < ST_VINIT) begin
      bitv = 64'd1 << (62 - 2 * SQJ);
      if (d_i.rem >= d_i.root + bitv) begin
        q_o.rem  = d_i.rem - (d_i.root + bitv);
        q_o.root = (d_i.root >> 1) + bitv;
      end else begin
        q_o.root = d_i.root >> 1;
      end
    end else if (STAGE == ST_VINIT) begin
      if (d_i.root == '0) begin
        q_o.lin = 1'b1;
      end
      q_o.sw = d_i.root[CW-1:0] << SH;
      q_o.vx = {{(CW-32){1'b0}}, d_i.c} << SH;
      q_o.vy = d_i.root[CW-1:0] << SH;
      q_o.vz = '0;
    end else if (STAGE >= ST_VEC && STAGE < ST_THETA) begin
      xa = $signed(d_i.vx);
      ya = $signed(d_i.vy);
      za = $signed(d_i.vz);
      xs = xa >>> VI;
      ys = ya >>> VI;
      if (ya >= 0) begin
        q_o.vx = xa + ys;
        q_o.vy = ya - xs;
        q_o.vz = za + ANG_V;
      end else begin
        q_o.vx = xa - ys;
        q_o.vy = ya + xs;
        q_o.vz = za - ANG_V;
      end
    end else if (STAGE == ST_THETA) begin
      om   = ($signed(d_i.vz) < 0) ? '0 : $signed(d_i.vz);
      w0   = ONE_C - tt;
      pa   = {{(63-FRAC_BITS){1'b0}}, w0[FRAC_BITS:0]} * {29'd0, om[34:0]};
      pb   = {{(63-FRAC_BITS){1'b0}}, tt[FRAC_BITS:0]} * {29'd0, om[34:0]};
      pa   = pa >> FRAC_BITS;
      pb   = pb >> FRAC_BITS;
      q_o.z0 = pa[CW-1:0];
      q_o.z1 = pb[CW-1:0];
      q_o.x0 = CORDIC_GAIN;
      q_o.x1 = CORDIC_GAIN;
      q_o.y0 = '0;
      q_o.y1 = '0;
    end else if (STAGE >= ST_ROT && STAGE < ST_WINIT) begin
      xa = $signed(d_i.x0);
      ya = $signed(d_i.y0);
      za = $signed(d_i.z0);
      xb = $signed(d_i.x1);
      yb = $signed(d_i.y1);
      zb = $signed(d_i.z1);
      if (za >= 0) begin
        q_o.x0 = xa - (ya >>> RI);
        q_o.y0 = ya + (xa >>> RI);
        q_o.z0 = za - ANG_R;
      end else begin
        q_o.x0 = xa + (ya >>> RI);
        q_o.y0 = ya - (xa >>> RI);
        q_o.z0 = za + ANG_R;
      end
      if (zb >= 0) begin
        q_o.x1 = xb - (yb >>> RI);
        q_o.y1 = yb + (xb >>> RI);
        q_o.z1 = zb - ANG_R;
      end else begin
        q_o.x1 = xb + (yb >>> RI);
        q_o.y1 = yb - (xb >>> RI);
        q_o.z1 = zb + ANG_R;
      end
    end else if (STAGE == ST_WINIT) begin
      dsh     = {{(DW-CW){1'b0}}, d_i.sw} << DIV_N;
      ya      = $signed(d_i.y0);
      mag     = (ya < 0) ? -ya : ya;
      n       = {{(DW-CW){1'b0}}, mag} << FRAC_BITS;
      q_o.ng0 = ya < 0;
      q_o.n0  = n;
      q_o.ov0 = n >= dsh;
      q_o.q0  = '0;
      yb      = $signed(d_i.y1);
      mag     = (yb < 0) ? -yb : yb;
      n       = {{(DW-CW){1'b0}}, mag} << FRAC_BITS;
      q_o.ng1 = yb < 0;
      q_o.n1  = n;
      q_o.ov1 = n >= dsh;
      q_o.q1  = '0;
    end else if (STAGE >= ST_DIV && STAGE < ST_KFIN) begin
      dsh = {{(DW-CW){1'b0}}, d_i.sw} << POS;
      if (d_i.n0 >= dsh) begin
        q_o.n0 = d_i.n0 - dsh;
        q_o.q0 = d_i.q0 | (CW'(1) << POS);
      end
      if (d_i.n1 >= dsh) begin
        q_o.n1 = d_i.n1 - dsh;
        q_o.q1 = d_i.q1 | (CW'(1) << POS);
      end
    end else if (STAGE == ST_KFIN) begin
      kk = (d_i.ov0 || d_i.q0 > KMAX) ? KMAX : $signed(d_i.q0);
      kl = (d_i.ov1 || d_i.q1 > KMAX) ? KMAX : $signed(d_i.q1);
      q_o.k0 = d_i.ng0 ? -kk : kk;
      q_o.k1 = d_i.ng1 ? -kl : kl;
      if (d_i.lin) begin
        q_o.k0 = ONE_C - tt;
        q_o.k1 = tt;
      end
    end else if (STAGE == ST_MUL) begin
      for (int i = 0; i < 4; i++) begin
        ma = $signed(d_i.k0[KW-1:0]) * $signed(d_i.a[i]);
        mb = $signed(d_i.k1[KW-1:0]) * $signed(d_i.b[i]);
        q_o.m0[i] = ma;
        q_o.m1[i] = mb;
      end
    end else if (STAGE == ST_SUM) begin
      for (int i = 0; i < 4; i++) begin
        sm = $signed(d_i.m0[i]) + $signed(d_i.m1[i]);
        sv = sm >>> FRAC_BITS;
        if (sv > SAT_HI) begin
          q_o.res[i] = SAT_HI;
        end else if (sv < SAT_LO) begin
          q_o.res[i] = SAT_LO;
        end else begin
          q_o.res[i] = sv[FIELD_W-1:0];
        end
        if (d_i.byp_a) begin
          q_o.res[i] = d_i.a[i];
        end else if (d_i.byp_b) begin
          q_o.res[i] = d_i.b[i][FIELD_W-1:0];
        end
      end
      q_o.ul = d_i.lin && !d_i.byp_a && !d_i.byp_b;
    end
  end

endmodule

FILE: design/quaternion_slerp_unit.sv
// Top level of the quaternion slerp unit: input register, stage pipeline, APB register.
//
// The unit interpolates between two Q2.22 quaternions along the shorter arc and
// takes one item per clock cycle unless its input is stalled. Every item runs
// through the same fixed pipeline of FRAC_BITS + 2*CORDIC_STEPS + 46 register
// stages, in this order: dot product and sign fix, a 32-stage square root,
// CORDIC_STEPS stages of CORDIC vectoring, a theta multiply, CORDIC_STEPS stages
// of CORDIC rotation that produce both sines side by side, a FRAC_BITS + 3 stage
// restoring divider for the two weights, and the final multiply, sum and
// saturation. Items that bypass the spherical math (blend at or below zero, at
// or above one, or close inputs) take the same path so that order is kept. The
// whole pipeline advances together; while a result waits on a stalled output,
// the unit stalls its input, and while the output stage is empty the pipeline
// keeps moving even if the output is stalled. The close threshold register lies
// at byte address 0 of the APB port and may only be written while the unit is
// idle.
module quaternion_slerp_unit import qslerp_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] a_w_i,
  input  logic signed [FIELD_W-1:0] a_x_i,
  input  logic signed [FIELD_W-1:0] a_y_i,
  input  logic signed [FIELD_W-1:0] a_z_i,
  input  logic signed [FIELD_W-1:0] b_w_i,
  input  logic signed [FIELD_W-1:0] b_x_i,
  input  logic signed [FIELD_W-1:0] b_y_i,
  input  logic signed [FIELD_W-1:0] b_z_i,
  input  logic signed [FIELD_W-1:0] blend_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [FIELD_W-1:0] res_w_o,
  output logic signed [FIELD_W-1:0] res_x_o,
  output logic signed [FIELD_W-1:0] res_y_o,
  output logic signed [FIELD_W-1:0] res_z_o,
  output logic                      used_linear_o
);

  localparam int N     = stage_count(FRAC_BITS, CORDIC_STEPS);
  localparam int ST_K  = N - 2;
  localparam logic signed [CW-1:0] KMAX = CW'(64'd1 << (FRAC_BITS + 2));

  logic [THR_W-1:0] thr_q;
  qs_item_t         pipe_q [0:N];
  qs_item_t         nxt    [0:N];
  logic [N:0]       v_q;
  logic             en_all;
  logic             reg_hit;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = paddr[ADDR_W-1:2] == REG_CLOSE_THR;
  assign prdata  = reg_hit ? {{(DATA_W-THR_W){1'b0}}, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // The pipeline moves whenever the output stage is empty or being taken.
  assign en_all     = !v_q[N] || !out_stall_i;
  assign in_stall_o = !en_all;

  always_comb begin
    nxt[0]      = '0;
    nxt[0].a[0] = a_w_i;
    nxt[0].a[1] = a_x_i;
    nxt[0].a[2] = a_y_i;
    nxt[0].a[3] = a_z_i;
    nxt[0].b[0] = {b_w_i[FIELD_W-1], b_w_i};
    nxt[0].b[1] = {b_x_i[FIELD_W-1], b_x_i};
    nxt[0].b[2] = {b_y_i[FIELD_W-1], b_y_i};
    nxt[0].b[3] = {b_z_i[FIELD_W-1], b_z_i};
    nxt[0].t    = blend_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_all) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_all) begin
      pipe_q[0] <= nxt[0];
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    qslerp_step #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS),
      .STAGE        (k)
    ) u_step (
      .thr_i (thr_q),
      .d_i   (pipe_q[k-1]),
      .q_o   (nxt[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_all) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_all) begin
        pipe_q[k] <= nxt[k];
      end
    end
  end

  assign out_valid_o   = v_q[N];
  assign res_w_o       = pipe_q[N].res[0];
  assign res_x_o       = pipe_q[N].res[1];
  assign res_y_o       = pipe_q[N].res[2];
  assign res_z_o       = pipe_q[N].res[3];
  assign used_linear_o = pipe_q[N].ul;

  // Valid bits follow the data one stage per advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_all |=> v_q[1] == $past(v_q[0]))
    else $error("valid bit did not follow its item into stage one");

  // Items that bypass the spherical path never report linear weights.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[N] && pipe_q[N].ul |-> !pipe_q[N].byp_a && !pipe_q[N].byp_b)
    else $error("bypassed item flagged as linear");

  // The cosine is non-negative once the sign fix is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> !pipe_q[3].cosv[CW-1])
    else $error("cosine negative after sign fix");

  // Spherical weights stay within four times unity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_K] && !pipe_q[ST_K].lin |->
      $signed(pipe_q[ST_K].k0) <= KMAX && $signed(pipe_q[ST_K].k0) >= -KMAX &&
      $signed(pipe_q[ST_K].k1) <= KMAX && $signed(pipe_q[ST_K].k1) >= -KMAX)
    else $error("weight outside its clamp range");

endmodule
